[rtl/core/portal_nearest_goal_point_macros.svh]
// Assertion macros for the portal goal point block
`ifndef PORTAL_NEAREST_GOAL_POINT_MACROS_SVH
`define PORTAL_NEAREST_GOAL_POINT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PNGP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pngp: check failed");
// next-cycle implication
`define PNGP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pngp: check failed");
`else
`define PNGP_ASSERT_NOW(lbl, pre, post)
`define PNGP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/pngp_pkg.sv]
// Shared types, constants and step functions of the portal goal point block
`timescale 1ns / 1ps
package pngp_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // unit direction limits (+/- 1.0)
  localparam logic signed [17:0] UNIT_POS = 18'sd65536;
  localparam logic signed [17:0] UNIT_NEG = -18'sd65536;

  // root and divider geometry
  localparam int SQ_IN_W    = 68;
  localparam int SQ_ROOT_W  = 34;
  localparam int SQ_STAGES  = 34;
  localparam int DIV_N_W    = 70;
  localparam int DIV_D_W    = 34;
  localparam int DIV_Q_W    = 35;
  localparam int DIV_STAGES = 35;

  typedef enum logic [2:0] {
    CASE_PROJ      = 3'd0,
    CASE_TAN_START = 3'd1,
    CASE_TAN_END   = 3'd2,
    CASE_OVERLAP   = 3'd3,
    CASE_TOO_LARGE = 3'd4
  } case_code_t;

  typedef enum logic [1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } reg_idx_t;

  // portal endpoints and derived unit direction
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic [33:0]        mag;
  } geom_t;

  typedef struct packed {
    logic [35:0]          rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_state_t;

  typedef struct packed {
    logic [DIV_N_W-1:0] rem;
    logic [DIV_N_W-1:0] dsh;
    logic [DIV_Q_W-1:0] quo;
  } div_state_t;

  // one digit of the bitwise integer square root
  function automatic sq_state_t sqrt_step(input sq_state_t s, input logic [1:0] pair);
    logic [36:0] rem_sh;
    logic [36:0] trial;
    sq_state_t   r;
    rem_sh = {s.rem[34:0], pair};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = 36'(rem_sh - trial);
      r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh[35:0];
      r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of restoring division
  function automatic div_state_t div_step(input div_state_t s);
    div_state_t r;
    r.dsh = s.dsh >> 1;
    if (s.rem >= s.dsh) begin
      r.rem = s.rem - s.dsh;
      r.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
    end else begin
      r.rem = s.rem;
      r.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // clamp to a signed coordinate
  function automatic logic signed [31:0] sat_coord(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/portal_nearest_goal_point.sv]
// Top level: portal goal point query pipeline
`timescale 1ns / 1ps
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the portal endpoints
//   (index 0..3: start_x, start_y, end_x, end_y). A write is taken only once
//   no query is in flight, and in_tready stays low while a write is offered.
//   After each write the block recomputes the portal length and unit
//   direction (one root unit step or one divide step per cycle);
//   cfg_ready and in_tready stay low meanwhile.
//   The in_ word is an agent query (x, y, radius), the out_ word its goal
//   point and case code. One word per cycle is taken in steady state while
//   the output is not stalled; each word passes the 34-stage root units
//   (run side by side) and then the two 35-stage divides in series of the
//   tangent path before out_tvalid. Every query goes through the full depth.
//   When the receiver holds out_tready low with a word waiting, the whole
//   pipeline freezes and in_tready drops; no word is lost or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   portal (0,0)-(1.0,0).
`include "portal_nearest_goal_point_macros.svh"
module portal_nearest_goal_point import pngp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // agent_x[31:0], agent_y[63:32], agent_radius[94:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // goal_x[31:0], goal_y[63:32]
  output logic [2:0]  out_tuser,  // case_code[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PIPE_LAT = 5 + SQ_STAGES + 2 + DIV_STAGES + 1 + DIV_STAGES + 1;
  localparam logic [51:0] ADJ_52 = 52'((1 << FRAC_BITS) - 1);
  localparam logic [53:0] ADJ_54 = 54'((1 << FRAC_BITS) - 1);

  // per-query fields kept alongside the root and divide stages
  typedef struct packed {
    case_code_t         code;
    logic               tan;
    logic               d2zero;
    logic               at_start;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [30:0]        rad;
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } tail_t;

  typedef struct packed {
    tail_t       tl;
    logic        nx_neg;
    logic        ny_neg;
    logic [33:0] d;
  } dpl_t;

  geom_t geom;
  logic  cfg_busy;
  logic  cfg_rdy_c;
  logic  pipe_empty;
  logic  en;
  logic  in_acc;
  logic [PIPE_LAT-1:0] vld_r;

  // register writes wait until no query is in flight
  assign pipe_empty = !(|vld_r);
  assign cfg_ready  = cfg_rdy_c && pipe_empty;

  pngp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && pipe_empty),
    .cfg_ready (cfg_rdy_c),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (cfg_busy)
  );

  // whole pipeline advances unless a finished word is held
  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en && !cfg_busy && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_acc};
    end
  end

  // stage 1: offsets from the start point, reach check
  logic signed [31:0] ax_in, ay_in;
  logic [30:0]        rad_in;
  logic signed [31:0] s1_ax_r, s1_ay_r;
  logic [30:0]        s1_rad_r;
  logic signed [32:0] s1_rx_r, s1_ry_r;
  logic               s1_big_r;

  assign ax_in  = in_tdata[31:0];
  assign ay_in  = in_tdata[63:32];
  assign rad_in = in_tdata[94:64];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r  <= ax_in;
      s1_ay_r  <= ay_in;
      s1_rad_r <= rad_in;
      s1_rx_r  <= 33'(ax_in) - 33'(geom.sx);
      s1_ry_r  <= 33'(ay_in) - 33'(geom.sy);
      s1_big_r <= geom.mag <= {3'b0, rad_in};
    end
  end

  // stage 2: projection products
  logic signed [31:0] s2_ax_r, s2_ay_r;
  logic [30:0]        s2_rad_r;
  logic               s2_big_r;
  logic signed [50:0] s2_prx_r, s2_pry_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_rad_r <= s1_rad_r;
      s2_big_r <= s1_big_r;
      s2_prx_r <= s1_rx_r * geom.ux;
      s2_pry_r <= s1_ry_r * geom.uy;
    end
  end

  // stage 3: projection length, side selection
  logic signed [51:0] sum_c, sum_adj_c;
  logic signed [35:0] dp_c, lim_c, rad_s_c;
  logic               at_start_c;
  logic signed [31:0] bx_c, by_c;

  always_comb begin
    sum_c      = 52'(s2_prx_r) + 52'(s2_pry_r);
    sum_adj_c  = sum_c + (sum_c[51] ? ADJ_52 : 52'd0);
    dp_c       = sum_adj_c[51:FRAC_BITS];
    rad_s_c    = $signed({5'b0, s2_rad_r});
    lim_c      = $signed({2'b0, geom.mag}) - rad_s_c;
    at_start_c = dp_c < rad_s_c;
    bx_c       = at_start_c ? geom.sx : geom.ex;
    by_c       = at_start_c ? geom.sy : geom.ey;
  end

  logic signed [31:0] s3_ax_r, s3_ay_r, s3_bx_r, s3_by_r;
  logic [30:0]        s3_rad_r;
  logic               s3_big_r, s3_proj_r, s3_at_start_r;
  logic signed [35:0] s3_dp_r;
  logic signed [32:0] s3_px_r, s3_py_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ax_r       <= s2_ax_r;
      s3_ay_r       <= s2_ay_r;
      s3_rad_r      <= s2_rad_r;
      s3_big_r      <= s2_big_r;
      s3_dp_r       <= dp_c;
      s3_proj_r     <= (dp_c >= rad_s_c) && (dp_c <= lim_c);
      s3_at_start_r <= at_start_c;
      s3_bx_r       <= bx_c;
      s3_by_r       <= by_c;
      s3_px_r       <= 33'(s2_ax_r) - 33'(bx_c);
      s3_py_r       <= 33'(s2_ay_r) - 33'(by_c);
    end
  end

  // stage 4: projected offset and squared distances
  logic signed [31:0] s4_ax_r, s4_ay_r, s4_bx_r, s4_by_r;
  logic [30:0]        s4_rad_r;
  logic               s4_big_r, s4_proj_r, s4_at_start_r;
  logic signed [32:0] s4_px_r, s4_py_r;
  logic signed [53:0] s4_pux_r, s4_puy_r;
  logic signed [67:0] s4_sqx_r, s4_sqy_r;
  logic [61:0]        s4_rsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ax_r       <= s3_ax_r;
      s4_ay_r       <= s3_ay_r;
      s4_bx_r       <= s3_bx_r;
      s4_by_r       <= s3_by_r;
      s4_rad_r      <= s3_rad_r;
      s4_big_r      <= s3_big_r;
      s4_proj_r     <= s3_proj_r;
      s4_at_start_r <= s3_at_start_r;
      s4_px_r       <= s3_px_r;
      s4_py_r       <= s3_py_r;
      s4_pux_r      <= geom.ux * s3_dp_r;
      s4_puy_r      <= geom.uy * s3_dp_r;
      s4_sqx_r      <= s3_px_r * s3_px_r;
      s4_sqy_r      <= s3_py_r * s3_py_r;
      s4_rsq_r      <= s3_rad_r * s3_rad_r;
    end
  end

  // stage 5: goals of the simple cases, root operands
  logic [53:0]        pux_adj_c, puy_adj_c;
  logic signed [37:0] pux_q_c, puy_q_c;
  logic [67:0]        d2_c;
  logic               ovl_c;
  logic signed [32:0] ovx_c, ovy_c;
  tail_t              tl_c;

  always_comb begin
    pux_adj_c = s4_pux_r + (s4_pux_r[53] ? ADJ_54 : 54'd0);
    puy_adj_c = s4_puy_r + (s4_puy_r[53] ? ADJ_54 : 54'd0);
    pux_q_c   = pux_adj_c[53:FRAC_BITS];
    puy_q_c   = puy_adj_c[53:FRAC_BITS];
    d2_c      = $unsigned(s4_sqx_r) + $unsigned(s4_sqy_r);
    ovl_c     = {6'b0, s4_rsq_r} > d2_c;
    ovx_c     = s4_at_start_r ? 33'(s4_ax_r) + 33'(geom.ux) : 33'(s4_ax_r) - 33'(geom.ux);
    ovy_c     = s4_at_start_r ? 33'(s4_ay_r) + 33'(geom.uy) : 33'(s4_ay_r) - 33'(geom.uy);

    tl_c.tan      = 1'b0;
    tl_c.d2zero   = (d2_c == '0);
    tl_c.at_start = s4_at_start_r;
    tl_c.rad      = s4_rad_r;
    tl_c.px       = s4_px_r;
    tl_c.py       = s4_py_r;
    tl_c.bx       = s4_bx_r;
    tl_c.by       = s4_by_r;
    if (s4_big_r) begin
      tl_c.code = CASE_TOO_LARGE;
      tl_c.gx   = s4_ax_r;
      tl_c.gy   = s4_ay_r;
    end else if (s4_proj_r) begin
      tl_c.code = CASE_PROJ;
      tl_c.gx   = sat_coord(40'(geom.sx) + 40'(pux_q_c));
      tl_c.gy   = sat_coord(40'(geom.sy) + 40'(puy_q_c));
    end else if (ovl_c) begin
      tl_c.code = CASE_OVERLAP;
      tl_c.gx   = sat_coord(40'(ovx_c));
      tl_c.gy   = sat_coord(40'(ovy_c));
    end else begin
      tl_c.code = s4_at_start_r ? CASE_TAN_START : CASE_TAN_END;
      tl_c.tan  = 1'b1;
      tl_c.gx   = s4_bx_r;
      tl_c.gy   = s4_by_r;
    end
  end

  logic [67:0] s5_d2_r, s5_l2_r;
  tail_t       s5_tl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_d2_r <= d2_c;
      s5_l2_r <= d2_c - {6'b0, s4_rsq_r};
      s5_tl_r <= tl_c;
    end
  end

  // distance and tangent length roots
  logic [SQ_ROOT_W-1:0] d_root, l_root;
  tail_t                sq_tl_r [SQ_STAGES];

  pngp_sqrt_pipe u_sqrt_d (.clk(clk), .en(en), .radicand(s5_d2_r), .root(d_root));
  pngp_sqrt_pipe u_sqrt_l (.clk(clk), .en(en), .radicand(s5_l2_r), .root(l_root));

  always_ff @(posedge clk) begin
    if (en) begin
      sq_tl_r[0] <= s5_tl_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sq_tl_r[k] <= sq_tl_r[k-1];
      end
    end
  end

  // stage 6: rotated offset products
  tail_t              sq_out_c;
  tail_t              s6_tl_r;
  logic [33:0]        s6_d_r;
  logic signed [69:0] s6_rpx_r, s6_rpy_r, s6_lpx_r, s6_lpy_r;

  assign sq_out_c = sq_tl_r[SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tl_r  <= sq_out_c;
      s6_d_r   <= d_root;
      s6_rpx_r <= $signed({1'b0, sq_out_c.rad}) * $signed(sq_out_c.px);
      s6_rpy_r <= $signed({1'b0, sq_out_c.rad}) * $signed(sq_out_c.py);
      s6_lpx_r <= $signed({1'b0, l_root}) * $signed(sq_out_c.px);
      s6_lpy_r <= $signed({1'b0, l_root}) * $signed(sq_out_c.py);
    end
  end

  // stage 7: rotated vector, split into sign and magnitude
  logic signed [69:0] nx_c, ny_c;
  logic [69:0]        s7_nxm_r, s7_nym_r;
  dpl_t               s7_pl_r;

  always_comb begin
    if (s6_tl_r.at_start) begin
      nx_c = s6_rpx_r + s6_lpy_r;
      ny_c = s6_rpy_r - s6_lpx_r;
    end else begin
      nx_c = s6_rpx_r - s6_lpy_r;
      ny_c = s6_rpy_r + s6_lpx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nxm_r       <= nx_c[69] ? 70'(-nx_c) : 70'(nx_c);
      s7_nym_r       <= ny_c[69] ? 70'(-ny_c) : 70'(ny_c);
      s7_pl_r.tl     <= s6_tl_r;
      s7_pl_r.nx_neg <= nx_c[69];
      s7_pl_r.ny_neg <= ny_c[69];
      s7_pl_r.d      <= s6_d_r;
    end
  end

  // first divide: n / d
  logic [DIV_Q_W-1:0] q1x, q1y;
  dpl_t               d1_pl_r [DIV_STAGES];

  pngp_div_pipe u_div1_x (.clk(clk), .en(en), .numer(s7_nxm_r), .denom(s7_pl_r.d), .quot(q1x));
  pngp_div_pipe u_div1_y (.clk(clk), .en(en), .numer(s7_nym_r), .denom(s7_pl_r.d), .quot(q1y));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_pl_r[0] <= s7_pl_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d1_pl_r[k] <= d1_pl_r[k-1];
      end
    end
  end

  // stage 8: scale by the radius
  dpl_t        d1_out_c;
  dpl_t        s8_pl_r;
  logic [69:0] s8_mx_r, s8_my_r;

  assign d1_out_c = d1_pl_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s8_pl_r <= d1_out_c;
      s8_mx_r <= d1_out_c.tl.rad * q1x;
      s8_my_r <= d1_out_c.tl.rad * q1y;
    end
  end

  // second divide: r * (n / d) / d
  logic [DIV_Q_W-1:0] q2x, q2y;
  dpl_t               d2_pl_r [DIV_STAGES];

  pngp_div_pipe u_div2_x (.clk(clk), .en(en), .numer(s8_mx_r), .denom(s8_pl_r.d), .quot(q2x));
  pngp_div_pipe u_div2_y (.clk(clk), .en(en), .numer(s8_my_r), .denom(s8_pl_r.d), .quot(q2y));

  always_ff @(posedge clk) begin
    if (en) begin
      d2_pl_r[0] <= s8_pl_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d2_pl_r[k] <= d2_pl_r[k-1];
      end
    end
  end

  // output stage: tangent goal or the goal chosen earlier
  dpl_t               d2_out_c;
  logic signed [35:0] ox_c, oy_c;
  logic signed [31:0] out_gx_r, out_gy_r;
  case_code_t         out_code_r;

  always_comb begin
    d2_out_c = d2_pl_r[DIV_STAGES-1];
    if (d2_out_c.tl.d2zero) begin
      ox_c = '0;
      oy_c = '0;
    end else begin
      ox_c = d2_out_c.nx_neg ? -$signed({1'b0, q2x}) : $signed({1'b0, q2x});
      oy_c = d2_out_c.ny_neg ? -$signed({1'b0, q2y}) : $signed({1'b0, q2y});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_code_r <= d2_out_c.tl.code;
      if (d2_out_c.tl.tan) begin
        out_gx_r <= sat_coord(40'(d2_out_c.tl.bx) + 40'(ox_c));
        out_gy_r <= sat_coord(40'(d2_out_c.tl.by) + 40'(oy_c));
      end else begin
        out_gx_r <= d2_out_c.tl.gx;
        out_gy_r <= d2_out_c.tl.gy;
      end
    end
  end

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {out_gy_r, out_gx_r};
  assign out_tuser  = out_code_r;

  // checks
  `PNGP_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_tready)
  `PNGP_ASSERT_NEXT(a_stall_holds_pipe, out_tvalid && !out_tready, $stable(vld_r))
  `PNGP_ASSERT_NOW(a_unit_dir_bounded, !cfg_busy,
    (geom.ux <= UNIT_POS) && (geom.ux >= UNIT_NEG) && (geom.uy <= UNIT_POS) && (geom.uy >= UNIT_NEG))

endmodule

[rtl/core/pngp_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module pngp_sqrt_pipe import pngp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_IN_W-1:0]   radicand,
  output logic [SQ_ROOT_W-1:0] root
);

  sq_state_t          st_r  [SQ_STAGES];
  logic [SQ_IN_W-1:0] num_r [SQ_STAGES-1];

  // first digit straight from the input
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= sqrt_step('0, radicand[SQ_IN_W-1 -: 2]);
      num_r[0] <= radicand << 2;
    end
  end

  for (genvar k = 1; k < SQ_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= sqrt_step(st_r[k-1], num_r[k-1][SQ_IN_W-1 -: 2]);
      end
    end
    if (k < SQ_STAGES - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k] <= num_r[k-1] << 2;
        end
      end
    end
  end

  assign root = st_r[SQ_STAGES-1].root;

endmodule

[rtl/core/pngp_div_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module pngp_div_pipe import pngp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DIV_N_W-1:0] numer,
  input  logic [DIV_D_W-1:0] denom,
  output logic [DIV_Q_W-1:0] quot
);

  div_state_t st_r [DIV_STAGES];
  div_state_t init_c;

  // divisor starts aligned to the top quotient bit
  always_comb begin
    init_c.rem = numer;
    init_c.dsh = {{(DIV_N_W - DIV_D_W - DIV_Q_W + 1){1'b0}}, denom, {(DIV_Q_W-1){1'b0}}};
    init_c.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(init_c);
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign quot = st_r[DIV_STAGES-1].quo;

endmodule

[rtl/core/pngp_cfg.sv]
// Portal registers and sequential derivation of length and unit direction
`timescale 1ns / 1ps
module pngp_cfg import pngp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output geom_t       geom,
  output logic        busy
);

  typedef enum logic [4:0] {
    CS_IDLE = 5'b00001,
    CS_LOAD = 5'b00010,
    CS_SQRT = 5'b00100,
    CS_DIVX = 5'b01000,
    CS_DIVY = 5'b10000
  } cfg_state_t;

  localparam logic [5:0] SQ_LAST  = 6'(SQ_STAGES - 1);
  localparam logic [5:0] DIV_DONE = 6'(DIV_STAGES + 1);

  cfg_state_t         state_r;
  logic [5:0]         cnt_r;
  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [17:0] ux_r, uy_r;
  logic [33:0]        mag_r;
  sq_state_t          sq_r;
  logic [SQ_IN_W-1:0] num_r;
  div_state_t         dv_r;

  logic signed [32:0]  dx_c, dy_c;
  logic [32:0]         adx_c, ady_c;
  logic signed [67:0]  sqx_c, sqy_c;
  logic signed [17:0]  q_c;

  // portal delta and its magnitude per axis
  always_comb begin
    dx_c  = 33'(ex_r) - 33'(sx_r);
    dy_c  = 33'(ey_r) - 33'(sy_r);
    adx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    sqx_c = dx_c * dx_c;
    sqy_c = dy_c * dy_c;
    q_c   = $signed({1'b0, dv_r.quo[16:0]});
  end

  assign cfg_ready = (state_r == CS_IDLE);
  assign busy      = !cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      ex_r    <= 32'sd65536;
      ey_r    <= '0;
      ux_r    <= UNIT_POS;
      uy_r    <= '0;
      mag_r   <= 34'd65536;
    end else begin
      case (state_r)
        CS_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_START_X: sx_r <= cfg_data;
              REG_START_Y: sy_r <= cfg_data;
              REG_END_X:   ex_r <= cfg_data;
              REG_END_Y:   ey_r <= cfg_data;
              default: ;
            endcase
            state_r <= CS_LOAD;
          end
        end
        // squared length into the root unit
        CS_LOAD: begin
          num_r   <= SQ_IN_W'($unsigned(sqx_c) + $unsigned(sqy_c));
          sq_r    <= '0;
          cnt_r   <= '0;
          state_r <= CS_SQRT;
        end
        CS_SQRT: begin
          sq_r  <= sqrt_step(sq_r, num_r[SQ_IN_W-1 -: 2]);
          num_r <= num_r << 2;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == SQ_LAST) begin
            cnt_r   <= '0;
            state_r <= CS_DIVX;
          end
        end
        // ux = dx * ONE / mag
        CS_DIVX: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == '0) begin
            mag_r      <= sq_r.root;
            dv_r.rem   <= {21'd0, adx_c, 16'd0};
            dv_r.dsh   <= {2'b0, sq_r.root, 34'd0};
            dv_r.quo   <= '0;
            if (sq_r.root == '0) begin
              ux_r    <= '0;
              uy_r    <= '0;
              state_r <= CS_IDLE;
            end
          end else if (cnt_r == DIV_DONE) begin
            ux_r    <= dx_c[32] ? -q_c : q_c;
            cnt_r   <= '0;
            state_r <= CS_DIVY;
          end else begin
            dv_r <= div_step(dv_r);
          end
        end
        // uy = dy * ONE / mag
        CS_DIVY: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == '0) begin
            dv_r.rem <= {21'd0, ady_c, 16'd0};
            dv_r.dsh <= {2'b0, mag_r, 34'd0};
            dv_r.quo <= '0;
          end else if (cnt_r == DIV_DONE) begin
            uy_r    <= dy_c[32] ? -q_c : q_c;
            cnt_r   <= '0;
            state_r <= CS_IDLE;
          end else begin
            dv_r <= div_step(dv_r);
          end
        end
        default: state_r <= CS_IDLE;
      endcase
    end
  end

  always_comb begin
    geom.sx  = sx_r;
    geom.sy  = sy_r;
    geom.ex  = ex_r;
    geom.ey  = ey_r;
    geom.ux  = ux_r;
    geom.uy  = uy_r;
    geom.mag = mag_r;
  end

endmodule
